FILE: src/rmd_pkg.sv
// ---------------------------------------------------------------------------
// rmd_pkg
// Types, constants and step functions shared by the RIPEMD-160 engine.
// ---------------------------------------------------------------------------
package rmd_pkg;

  localparam int BlkWords = 16;
  localparam int AddrW    = 4;
  localparam int Steps    = 80;
  localparam int CountW   = 61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } rmd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } rmd_out_t;

  typedef struct packed {
    logic       iv;
    logic       load;
    logic       step;
    logic       fin;
    logic [6:0] idx;
  } rmd_ctl_t;

  typedef logic [4:0][31:0] rmd_chain_t;

  localparam logic [3:0] SEL_L [Steps] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [3:0] SEL_R [Steps] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [3:0] ROT_L [Steps] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

  localparam logic [3:0] ROT_R [Steps] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

  localparam logic [31:0] ADD_L [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] ADD_R [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};
  localparam logic [31:0] INIT_VEC [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};

  function automatic logic [31:0] rotl_f(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic logic [31:0] mix_f(input logic [2:0] k, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (k)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  function automatic logic [6:0] step_clip_f(input logic [6:0] j);
    return (j < 7'(Steps)) ? j : 7'd0;
  endfunction

endpackage

FILE: src/rmd_blk_ram.sv
// ---------------------------------------------------------------------------
// rmd_blk_ram
// Sixteen-word message block store, one write port, two registered reads.
// ---------------------------------------------------------------------------
module rmd_blk_ram import rmd_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [31:0]      rdata_a_o,
  output logic [31:0]      rdata_b_o
);

  logic [31:0] mem_q [BlkWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/rmd_round.sv
// ---------------------------------------------------------------------------
// rmd_round
// Left and right step datapaths, working registers and chaining value.
// ---------------------------------------------------------------------------
module rmd_round import rmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rmd_ctl_t    ctl_i,
  input  logic [31:0] wl_i,
  input  logic [31:0] wr_i,
  output rmd_chain_t  chain_o
);

  rmd_chain_t  chain_q, chain_d;
  logic [31:0] al_q, bl_q, cl_q, dl_q, el_q;
  logic [31:0] ar_q, br_q, cr_q, dr_q, er_q;
  logic [6:0]  idx;
  logic [2:0]  rnd, rnd_r;
  logic [31:0] sum_l, sum_r, t_l, t_r;

  assign idx   = step_clip_f(ctl_i.idx);
  assign rnd   = idx[6:4];
  assign rnd_r = 3'd4 - rnd;
  assign sum_l = al_q + mix_f(rnd, bl_q, cl_q, dl_q) + wl_i + ADD_L[rnd];
  assign sum_r = ar_q + mix_f(rnd_r, br_q, cr_q, dr_q) + wr_i + ADD_R[rnd];
  assign t_l   = rotl_f(sum_l, ROT_L[idx]) + el_q;
  assign t_r   = rotl_f(sum_r, ROT_R[idx]) + er_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      al_q <= chain_q[0]; bl_q <= chain_q[1]; cl_q <= chain_q[2];
      dl_q <= chain_q[3]; el_q <= chain_q[4];
      ar_q <= chain_q[0]; br_q <= chain_q[1]; cr_q <= chain_q[2];
      dr_q <= chain_q[3]; er_q <= chain_q[4];
    end else if (ctl_i.step) begin
      al_q <= el_q; el_q <= dl_q; dl_q <= rotl_f(cl_q, 4'd10); cl_q <= bl_q; bl_q <= t_l;
      ar_q <= er_q; er_q <= dr_q; dr_q <= rotl_f(cr_q, 4'd10); cr_q <= br_q; br_q <= t_r;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (ctl_i.iv) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = INIT_VEC[i];
      end
    end else if (ctl_i.fin) begin
      chain_d[0] = chain_q[1] + cl_q + dr_q;
      chain_d[1] = chain_q[2] + dl_q + er_q;
      chain_d[2] = chain_q[3] + el_q + ar_q;
      chain_d[3] = chain_q[4] + al_q + br_q;
      chain_d[4] = chain_q[0] + bl_q + cr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= INIT_VEC[i];
      end
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

FILE: src/ripemd160_hash_engine.sv
// ---------------------------------------------------------------------------
// ripemd160_hash_engine
// Byte-streaming RIPEMD-160: block packing, padding and digest sequencing.
// ---------------------------------------------------------------------------
// The byte that fills a block adds a compression (80 steps off the two-port
// block memory, plus load and chaining update). A last word adds a pad word,
// zero fill (up to 15 words), two length words and a compression, or 16 zero
// words and a second compression more when the length spills into a second
// block; then five digest words follow, one per unstalled cycle.
// Reset: chaining value to the initial vector, byte count zero; block
// memory contents are undefined until written.
module ripemd160_hash_engine import rmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rmd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rmd_out_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_LEN2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_q, state_d, ret_q, ret_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [4:0]        zw_q, zw_d;
  logic              two_q, two_d;
  logic [2:0]        k_q, k_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       acc_q, acc_d;

  logic              in_acc, out_acc;
  logic [5:0]        pos;
  logic [31:0]       byte_word, pad_word;
  logic [63:0]       bit_len;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [31:0]       wdata;
  logic [6:0]        ridx;
  logic [31:0]       rd_l, rd_r;
  rmd_ctl_t          ctl;
  rmd_chain_t        chain;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign pos       = count_q[5:0];
  assign byte_word = (pos[1:0] == 2'd0) ? {24'd0, in_data_i.data_byte}
                   : acc_q | ({24'd0, in_data_i.data_byte} << {pos[1:0], 3'b000});
  assign pad_word  = (pos[1:0] == 2'd0) ? 32'h0000_0080
                   : acc_q | (32'h0000_0080 << {pos[1:0], 3'b000});
  assign bit_len   = {count_q, 3'b000};
  assign ridx      = step_clip_f(cnt_q);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    zw_d    = zw_q;
    two_d   = two_q;
    k_d     = k_q;
    count_d = count_q;
    acc_d   = acc_q;
    we      = 1'b0;
    waddr   = pos[5:2];
    wdata   = byte_word;
    ctl     = '0;
    ctl.idx = cnt_q - 7'd1;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            we      = 1'b1;
            acc_d   = byte_word;
            count_d = count_q + {{(CountW-1){1'b0}}, 1'b1};
            if (pos == 6'd63) begin
              state_d = S_COMP;
              cnt_d   = 7'd0;
              ret_d   = in_data_i.is_last ? S_PAD : S_IDLE;
            end else if (in_data_i.is_last) begin
              state_d = S_PAD;
            end
          end else if (in_data_i.is_last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        we    = 1'b1;
        wdata = pad_word;
        if (pos[5:2] == 4'd15) begin
          state_d = S_COMP;
          cnt_d   = 7'd0;
          ret_d   = S_ZERO;
          zw_d    = 5'd0;
          two_d   = 1'b0;
        end else begin
          state_d = S_ZERO;
          zw_d    = {1'b0, pos[5:2]} + 5'd1;
          two_d   = (pos > 6'd55);
        end
      end
      S_ZERO: begin
        we    = 1'b1;
        waddr = zw_q[3:0];
        wdata = 32'd0;
        zw_d  = zw_q + 5'd1;
        if (zw_q[3:0] == 4'd15) begin
          if (two_q) begin
            state_d = S_COMP;
            cnt_d   = 7'd0;
            ret_d   = S_ZERO;
            zw_d    = 5'd0;
            two_d   = 1'b0;
          end else begin
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        we      = 1'b1;
        waddr   = 4'd14;
        wdata   = bit_len[31:0];
        state_d = S_LEN2;
      end
      S_LEN2: begin
        we      = 1'b1;
        waddr   = 4'd15;
        wdata   = bit_len[63:32];
        state_d = S_COMP;
        cnt_d   = 7'd0;
        ret_d   = S_OUT;
      end
      S_COMP: begin
        cnt_d    = cnt_q + 7'd1;
        ctl.load = (cnt_q == 7'd0);
        ctl.step = (cnt_q != 7'd0) && (cnt_q <= 7'(Steps));
        if (cnt_q == 7'(Steps + 1)) begin
          ctl.fin = 1'b1;
          state_d = ret_q;
          k_d     = 3'd0;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          k_d = k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_d = S_IDLE;
            ctl.iv  = 1'b1;
            count_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      zw_q    <= '0;
      two_q   <= 1'b0;
      k_q     <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      zw_q    <= zw_d;
      two_q   <= two_d;
      k_q     <= k_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  rmd_blk_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (SEL_L[ridx]),
    .raddr_b_i (SEL_R[ridx]),
    .rdata_a_o (rd_l),
    .rdata_b_o (rd_r)
  );

  rmd_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .wl_i    (rd_l),
    .wr_i    (rd_r),
    .chain_o (chain)
  );

  always_comb begin
    case (k_q)
      3'd0:    out_data_o.digest_word = chain[0];
      3'd1:    out_data_o.digest_word = chain[1];
      3'd2:    out_data_o.digest_word = chain[2];
      3'd3:    out_data_o.digest_word = chain[3];
      default: out_data_o.digest_word = chain[4];
    endcase
    out_data_o.word_index = k_q;
    out_data_o.last_word  = (k_q == 3'd4);
  end

endmodule

FILE: src/rmd_checker.sv
// ---------------------------------------------------------------------------
// rmd_checker
// Port-level checks on the digest word sequence of the hash engine and on input stalling during output.
// ---------------------------------------------------------------------------
module rmd_checker import rmd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rmd_out_t out_data_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest word changed while stalled");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd4)))
    else $error("last_word does not match word_index");

  a_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i |-> in_stall_o)
    else $error("input taken during digest output");

  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_o.last_word |=>
      out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest word sequence broken");

  a_end_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.last_word |=> !out_valid_o && !in_stall_o)
    else $error("engine not idle after final digest word");

endmodule

bind ripemd160_hash_engine rmd_checker u_rmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: dv/ripemd160_hash_engine_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ripemd160_hash_engine_tb
// Streams messages byte by byte into the engine and checks every digest word
// against a RIPEMD-160 computed in the bench, under random bursts and stalls.
// ---------------------------------------------------------------------------
module ripemd160_hash_engine_tb;
  import rmd_pkg::*;

  localparam int MSG_ORDER_L [80] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
    3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
    1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2,
    4, 0, 5, 9, 7, 12, 2, 10, 14, 1, 3, 8, 11, 6, 15, 13};
  localparam int MSG_ORDER_R [80] = '{
    5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
    6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
    15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
    8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14,
    12, 15, 10, 4, 1, 5, 8, 7, 6, 2, 13, 14, 0, 3, 9, 11};
  localparam int SHIFT_L [80] = '{
    11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
    7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
    11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
    11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12,
    9, 15, 5, 11, 6, 8, 13, 12, 5, 12, 13, 14, 11, 8, 5, 6};
  localparam int SHIFT_R [80] = '{
    8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
    9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
    9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
    15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8,
    8, 5, 12, 9, 12, 5, 14, 6, 8, 13, 6, 5, 15, 13, 11, 11};
  localparam logic [31:0] K_L [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] K_R [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};

  localparam int RANDOM_BYTES = 400;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  rmd_in_t  in_word   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  rmd_out_t out_data_o;

  rmd_in_t  feed_q [$];
  rmd_out_t digest_q [$];
  int       errors = 0;

  // bench copy of the hash state
  logic [31:0] chain_q [5];
  logic [31:0] blk [16];
  logic [60:0] byte_cnt;

  int burst_left = 0;
  int gap_left   = 0;
  int stall_mode = 0;
  int mode_left  = 0;
  rmd_out_t want;

  ripemd160_hash_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mixer(int k, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
    case (k)
      0: return x ^ y ^ z;
      1: return (x & y) | (~x & z);
      2: return (x | ~y) ^ z;
      3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic void absorb_block();
    logic [31:0] al, bl, cl, dl, el, ar, br, cr, dr, er, t;
    int j;
    int rnd;
    al = chain_q[0]; bl = chain_q[1]; cl = chain_q[2]; dl = chain_q[3]; el = chain_q[4];
    ar = al; br = bl; cr = cl; dr = dl; er = el;
    for (j = 0; j < 80; j++) begin
      rnd = j / 16;
      t = rol(al + mixer(rnd, bl, cl, dl) + blk[MSG_ORDER_L[j]] + K_L[rnd], SHIFT_L[j]) + el;
      al = el; el = dl; dl = rol(cl, 10); cl = bl; bl = t;
      t = rol(ar + mixer(4 - rnd, br, cr, dr) + blk[MSG_ORDER_R[j]] + K_R[rnd], SHIFT_R[j])
          + er;
      ar = er; er = dr; dr = rol(cr, 10); cr = br; br = t;
    end
    t          = chain_q[1] + cl + dr;
    chain_q[1] = chain_q[2] + dl + er;
    chain_q[2] = chain_q[3] + el + ar;
    chain_q[3] = chain_q[4] + al + br;
    chain_q[4] = chain_q[0] + bl + cr;
    chain_q[0] = t;
  endfunction

  function automatic void place_byte(logic [7:0] v, int pos);
    if (pos % 4 == 0) begin
      blk[pos / 4] = {24'h0, v};
    end else begin
      blk[pos / 4] = blk[pos / 4] | ({24'h0, v} << (8 * (pos % 4)));
    end
  endfunction

  // advance the hash by one accepted word; a last word queues the digest
  function automatic void absorb_item(rmd_in_t it);
    int pos;
    int w;
    int k;
    logic [63:0] nbits;
    rmd_out_t dw;
    if (it.has_byte) begin
      pos = int'(byte_cnt[5:0]);
      place_byte(it.data_byte, pos);
      byte_cnt = byte_cnt + 61'd1;
      if (pos == 63) absorb_block();
    end
    if (!it.is_last) return;
    pos = int'(byte_cnt[5:0]);
    place_byte(8'h80, pos);
    for (w = pos / 4 + 1; w < 16; w++) blk[w] = '0;
    if (pos > 55) begin
      absorb_block();
      for (w = 0; w < 16; w++) blk[w] = '0;
    end
    nbits = {byte_cnt, 3'b000};
    blk[14] = nbits[31:0];
    blk[15] = nbits[63:32];
    absorb_block();
    for (k = 0; k < 5; k++) begin
      dw.digest_word = chain_q[k];
      dw.word_index  = 3'(k);
      dw.last_word   = (k == 4);
      digest_q.push_back(dw);
    end
    for (k = 0; k < 5; k++) chain_q[k] = IV[k];
    byte_cnt = '0;
  endfunction

  // one message of len bytes with a few ignored words mixed in; returns bytes queued
  function automatic int queue_message(int len, bit byte_on_last);
    rmd_in_t it;
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        it.data_byte = 8'($urandom);
        it.has_byte  = 1'b0;
        it.is_last   = 1'b0;
        feed_q.push_back(it);
      end
      it.data_byte = 8'($urandom);
      it.has_byte  = 1'b1;
      it.is_last   = byte_on_last && (i == len - 1);
      feed_q.push_back(it);
    end
    if (!byte_on_last || len == 0) begin
      it.data_byte = 8'($urandom);
      it.has_byte  = 1'b0;
      it.is_last   = 1'b1;
      feed_q.push_back(it);
    end
    return len;
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall_o)) begin
      if (gap_left != 0 || feed_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_word  <= feed_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern switches between quiet, light, half and heavy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(4, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) absorb_item(in_word);
      if (out_valid_o && !out_stall) begin
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected digest word: expected none, actual %h", $time,
                   out_data_o);
        end else begin
          want = digest_q.pop_front();
          if (out_data_o.digest_word !== want.digest_word) begin
            errors++;
            $display("%0t: digest_word: expected %h, actual %h", $time,
                     want.digest_word, out_data_o.digest_word);
          end
          if (out_data_o.word_index !== want.word_index) begin
            errors++;
            $display("%0t: word_index: expected %0d, actual %0d", $time,
                     want.word_index, out_data_o.word_index);
          end
          if (out_data_o.last_word !== want.last_word) begin
            errors++;
            $display("%0t: last_word: expected %b, actual %b", $time,
                     want.last_word, out_data_o.last_word);
          end
        end
      end
    end
  end

  initial begin
    int nbytes;
    int len;
    int pick;
    for (int k = 0; k < 5; k++) chain_q[k] = IV[k];
    for (int k = 0; k < 16; k++) blk[k] = '0;
    byte_cnt = '0;

    // directed: empty message, ignored word, "abc", byte extremes
    feed_q.push_back('{data_byte: 8'h00, has_byte: 1'b0, is_last: 1'b1});
    feed_q.push_back('{data_byte: 8'hff, has_byte: 1'b0, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'h61, has_byte: 1'b1, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'h62, has_byte: 1'b1, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'h63, has_byte: 1'b1, is_last: 1'b1});
    feed_q.push_back('{data_byte: 8'hff, has_byte: 1'b1, is_last: 1'b1});
    feed_q.push_back('{data_byte: 8'h00, has_byte: 1'b1, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'hff, has_byte: 1'b0, is_last: 1'b1});
    feed_q.push_back('{data_byte: 8'h55, has_byte: 1'b0, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'haa, has_byte: 1'b0, is_last: 1'b1});
    feed_q.push_back('{data_byte: 8'h80, has_byte: 1'b1, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'h7f, has_byte: 1'b1, is_last: 1'b0});
    feed_q.push_back('{data_byte: 8'h01, has_byte: 1'b1, is_last: 1'b1});

    // random: mostly short messages, some around the padding and block edges
    nbytes = 0;
    while (nbytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = $urandom_range(0, 20);
      end else if (pick < 8) begin
        case ($urandom_range(0, 10))
          0: len = 54;
          1: len = 55;
          2: len = 56;
          3: len = 57;
          4: len = 62;
          5: len = 63;
          6: len = 64;
          7: len = 65;
          8: len = 119;
          9: len = 120;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(0, 140);
      end
      nbytes += queue_message(len, 1'($urandom_range(0, 1)));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || in_valid) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (errors == 0) begin
      $display("ripemd160_hash_engine: match");
    end else begin
      $display("ripemd160_hash_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ripemd160_hash_engine: mismatch");
    $finish;
  end

endmodule
